>>> rtl/insar_phase_to_topo_correction_unit_defines.svh
// Assertion macros for the port-level checker of the topography correction unit.
`ifndef INSAR_PHASE_TO_TOPO_CORRECTION_UNIT_DEFINES_SVH
`define INSAR_PHASE_TO_TOPO_CORRECTION_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPTC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("iptc check failed");

// The condition must never be true outside reset.
`define IPTC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("iptc check failed");

`endif

>>> rtl/iptc_pkg.sv
package iptc_pkg;

    // Field and register widths.
    localparam int COL_W      = 12;
    localparam int TOPO_W     = 25;
    localparam int PHASE_W    = 32;
    localparam int NEAR_W     = 32;
    localparam int SPACING_W  = 20;
    localparam int RADIUS_W   = 34;
    localparam int HEIGHT_W   = 32;
    localparam int GAIN_W     = 32;
    localparam int CFG_DATA_W = 34;
    localparam int CFG_IDX_W  = 3;

    localparam int MAX_COLUMNS_DEFAULT = 4096;

    // Internal widths of the geometry datapath.
    localparam int RHO_W  = 33;            // near range plus column offset
    localparam int C_W    = 35;            // platform radius
    localparam int RET_W  = 36;            // local radius, signed
    localparam int A_W    = 38;            // triangle terms, signed
    localparam int MAG_W  = 37;            // magnitude of a triangle term
    localparam int SQRT_SHIFT = 16;        // fraction bits added before the root
    localparam int ROOT_W = (2 * MAG_W + SQRT_SHIFT) / 2;
    localparam int N_W    = 2 * ROOT_W;    // product of the two roots
    localparam int D_W    = 36;            // twice the local radius
    localparam int Q_W    = 52;            // saturated quotient
    localparam int GP_W   = 2 * GAIN_W;    // gain times phase magnitude
    localparam int SUM_W  = 48;
    localparam int RND_SHIFT = 8;

    localparam int MUL_DIGIT = 16;
    localparam int NS_P = (MAG_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NS_R = (ROOT_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int NS_G = (Q_W + MUL_DIGIT - 1) / MUL_DIGIT;
    localparam int DLY1 = NS_P + ROOT_W + NS_R;

    // Accept edge to the edge at which done is seen high.
    localparam int PIPE_LAT = 3 + NS_P + ROOT_W + NS_R + 1 + Q_W + NS_G + 1;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 34'd6371000000;
    localparam logic signed [SUM_W-1:0] TOPO_MAX = 48'sd16777215;
    localparam logic signed [SUM_W-1:0] TOPO_MIN = -48'sd16777216;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_RANGE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SPACING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EARTH_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLATFORM_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NODATA_PHASE    = 3'd5;

    // Per-pixel values that ride alongside the long arithmetic.
    typedef struct packed {
        logic signed [TOPO_W-1:0] topo;
        logic                     nodata;
        logic                     err;
        logic                     qpos;
        logic                     neg;
        logic [GP_W-1:0]          gp;
        logic [D_W-1:0]           d;
    } side_t;

endpackage

>>> rtl/iptc_mul.sv
// Pipelined unsigned multiplier: one 16-bit digit of b per stage.
module iptc_mul #(
    parameter int WA = iptc_pkg::MAG_W,
    parameter int WB = iptc_pkg::MAG_W
) (
    input  logic             clk,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);
    import iptc_pkg::*;

    localparam int DW  = MUL_DIGIT;
    localparam int NS  = (WB + DW - 1) / DW;
    localparam int WBP = NS * DW;
    localparam int WP  = WA + WBP;

    logic [WA-1:0]  a_reg   [NS];
    logic [WBP-1:0] b_reg   [NS];
    logic [WP-1:0]  acc_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [WA-1:0]    a_in;
        logic [WBP-1:0]   b_in;
        logic [WP-1:0]    acc_in;
        logic [WA+DW-1:0] prod;

        if (k == 0) begin : g_first
            assign a_in   = a;
            assign b_in   = WBP'(b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = a_reg[k-1];
            assign b_in   = b_reg[k-1];
            assign acc_in = acc_reg[k-1];
        end

        // Partial product of this digit, added at its weight.
        assign prod = a_in * b_in[k*DW +: DW];

        always_ff @(posedge clk)
        begin
            a_reg[k]   <= a_in;
            b_reg[k]   <= b_in;
            acc_reg[k] <= acc_in + (WP'(prod) << (k * DW));
        end
    end

    assign p = acc_reg[NS-1][WA+WB-1:0];

endmodule

>>> rtl/iptc_sqrt.sv
// Pipelined integer square root: one root bit per stage, floor result.
module iptc_sqrt #(
    parameter int RW = iptc_pkg::ROOT_W
) (
    input  logic            clk,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);
    import iptc_pkg::*;

    logic [2*RW-1:0] x_reg    [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [2*RW-1:0] x_in;
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [RW+1:0]   rem_sh;
        logic [RW+1:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign x_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign x_in    = x_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        // Bring down the next two radicand bits and try a one bit.
        assign rem_sh = {rem_in[RW-1:0], x_in[2*RW-1-2*k -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            x_reg[k]    <= x_in;
            rem_reg[k]  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg[k] <= {root_in[RW-2:0], ge};
        end
    end

    assign root = root_reg[RW-1];

endmodule

>>> rtl/insar_phase_to_topo_correction_unit.sv
// Topography correction from residual interferometric phase. One pixel request is taken in
// every clock cycle; busy is always low. Each result appears on done in request order, after
// the input stages, two parallel 3-stage multipliers, two parallel 45-stage square roots, a
// 3-stage root product, the divider setup, the radius divider, the 4-stage gain multiplier
// and the output register. The receiver cannot stall the pipeline. Write configuration only
// while no pixel is in flight.
module insar_phase_to_topo_correction_unit #(
    parameter int MAX_COLUMNS = iptc_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [iptc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [iptc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [iptc_pkg::COL_W-1:0]            column,
    input  logic signed [iptc_pkg::TOPO_W-1:0]    topo_in,
    input  logic signed [iptc_pkg::PHASE_W-1:0]   residual_phase,
    output logic                                  done,
    output logic signed [iptc_pkg::TOPO_W-1:0]    topo_corr,
    output logic                                  geometry_error,
    output logic                                  was_nodata
);
    import iptc_pkg::*;

    // Configuration registers.
    logic [NEAR_W-1:0]    near_range_reg;
    logic [SPACING_W-1:0] range_spacing_reg;
    logic [RADIUS_W-1:0]  earth_radius_reg;
    logic [HEIGHT_W-1:0]  platform_height_reg;
    logic [GAIN_W-1:0]    phase_gain_reg;
    logic [PHASE_W-1:0]   nodata_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_range_reg      <= '0;
            range_spacing_reg   <= '0;
            earth_radius_reg    <= RADIUS_RESET;
            platform_height_reg <= '0;
            phase_gain_reg      <= '0;
            nodata_phase_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_NEAR_RANGE:      near_range_reg      <= cfg_data[NEAR_W-1:0];
                REG_RANGE_SPACING:   range_spacing_reg   <= cfg_data[SPACING_W-1:0];
                REG_EARTH_RADIUS:    earth_radius_reg    <= cfg_data[RADIUS_W-1:0];
                REG_PLATFORM_HEIGHT: platform_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_PHASE_GAIN:      phase_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_NODATA_PHASE:    nodata_phase_reg    <= cfg_data[PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline never stalls, so every request is taken.
    assign busy = 1'b0;

    // Valid bits travel alongside the data.
    logic [PIPE_LAT-1:0] v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[PIPE_LAT-2:0], start & ~busy};
    end

    // Stage 1: capture the request, clamping the column.
    logic [COL_W-1:0]          col_sat;
    logic [COL_W-1:0]          col1_reg;
    logic signed [TOPO_W-1:0]  topo1_reg;
    logic [PHASE_W-1:0]        phase1_reg;

    always_comb
    begin
        if (32'(column) > MAX_COLUMNS - 1)
            col_sat = COL_W'(MAX_COLUMNS - 1);
        else
            col_sat = column;
    end

    always_ff @(posedge clk)
    begin
        col1_reg   <= col_sat;
        topo1_reg  <= topo_in;
        phase1_reg <= residual_phase;
    end

    // Stage 2: slant range, local radius, nodata match and gain times phase.
    logic [RHO_W-1:0]         rho2_reg;
    logic signed [RET_W-1:0]  ret2_reg;
    logic signed [TOPO_W-1:0] topo2_reg;
    logic                     nodata2_reg;
    logic [GP_W-1:0]          gp2_reg;
    logic                     neg2_reg;
    logic [NEAR_W-1:0]        col_off;
    logic [GAIN_W-1:0]        gain_mag;
    logic [PHASE_W-1:0]       phase_mag;

    assign col_off   = col1_reg * range_spacing_reg;
    assign gain_mag  = phase_gain_reg[GAIN_W-1] ? (~phase_gain_reg + 1'b1) : phase_gain_reg;
    assign phase_mag = phase1_reg[PHASE_W-1] ? (~phase1_reg + 1'b1) : phase1_reg;

    always_ff @(posedge clk)
    begin
        rho2_reg    <= RHO_W'(near_range_reg) + RHO_W'(col_off);
        ret2_reg    <= $signed(RET_W'(earth_radius_reg)) + RET_W'(topo1_reg);
        topo2_reg   <= topo1_reg;
        nodata2_reg <= (phase1_reg == nodata_phase_reg);
        gp2_reg     <= gain_mag * phase_mag;
        neg2_reg    <= phase_gain_reg[GAIN_W-1] ^ phase1_reg[PHASE_W-1];
    end

    // Stage 3: triangle terms, their magnitudes and the geometry flags.
    logic [C_W-1:0]          plat_c;
    logic signed [A_W-1:0]   ra, rh, rc, a1, a2, a3, a4;
    logic [MAG_W-1:0]        m1_reg, m2_reg, m3_reg, m4_reg;
    side_t                   side3_reg;

    assign plat_c = C_W'(earth_radius_reg) + C_W'(platform_height_reg);
    assign ra = A_W'(ret2_reg);
    assign rh = $signed(A_W'(rho2_reg));
    assign rc = $signed(A_W'(plat_c));
    assign a1 = ra - rc + rh;
    assign a2 = ra + rc - rh;
    assign a3 = rh + rc - ra;
    assign a4 = rh + rc + ra;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [A_W-1:0] x);
        logic signed [A_W-1:0] n;
        n = x[A_W-1] ? -x : x;
        return n[MAG_W-1:0];
    endfunction

    function automatic logic both_pos(input logic signed [A_W-1:0] x,
                                      input logic signed [A_W-1:0] y);
        return (x != '0) && (y != '0) && (x[A_W-1] == y[A_W-1]);
    endfunction

    always_ff @(posedge clk)
    begin
        m1_reg <= mag_of(a1);
        m2_reg <= mag_of(a2);
        m3_reg <= mag_of(a3);
        m4_reg <= mag_of(a4);
        side3_reg.topo   <= topo2_reg;
        side3_reg.nodata <= nodata2_reg;
        side3_reg.err    <= (ret2_reg <= 0) || !both_pos(a1, a2);
        side3_reg.qpos   <= both_pos(a3, a4);
        side3_reg.neg    <= neg2_reg;
        side3_reg.gp     <= gp2_reg;
        side3_reg.d      <= {ret2_reg[D_W-2:0], 1'b0};
    end

    // Heron products, their roots and the product of the roots.
    logic [2*MAG_W-1:0] p_prod, q_prod;
    logic [ROOT_W-1:0]  p_root, q_root;
    logic [N_W-1:0]     n_prod;

    iptc_mul #(.WA(MAG_W), .WB(MAG_W)) u_mul_p (
        .clk (clk), .a (m1_reg), .b (m2_reg), .p (p_prod)
    );
    iptc_mul #(.WA(MAG_W), .WB(MAG_W)) u_mul_q (
        .clk (clk), .a (m3_reg), .b (m4_reg), .p (q_prod)
    );
    iptc_sqrt #(.RW(ROOT_W)) u_sqrt_p (
        .clk (clk), .radicand ({p_prod, SQRT_SHIFT'(0)}), .root (p_root)
    );
    iptc_sqrt #(.RW(ROOT_W)) u_sqrt_q (
        .clk (clk), .radicand ({q_prod, SQRT_SHIFT'(0)}), .root (q_root)
    );
    iptc_mul #(.WA(ROOT_W), .WB(ROOT_W)) u_mul_r (
        .clk (clk), .a (p_root), .b (q_root), .p (n_prod)
    );

    // Side values wait for the root product.
    side_t dly1_reg [DLY1];
    for (genvar k = 0; k < DLY1; k++) begin : g_dly1
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
                dly1_reg[k] <= side3_reg;
        end else begin : g_next
            always_ff @(posedge clk)
                dly1_reg[k] <= dly1_reg[k-1];
        end
    end

    // Divider setup: saturation check and the first partial remainder.
    logic [N_W-Q_W-1:0] n_high;
    logic [D_W-1:0]     dv_rem_reg;
    logic [Q_W-1:0]     dv_low_reg;
    logic               dv_sat_reg;
    side_t              dv_side_reg;

    assign n_high = n_prod[N_W-1:Q_W];

    always_ff @(posedge clk)
    begin
        dv_sat_reg  <= (n_high >= (N_W-Q_W)'(dly1_reg[DLY1-1].d));
        dv_rem_reg  <= n_high[D_W-1:0];
        dv_low_reg  <= n_prod[Q_W-1:0];
        dv_side_reg <= dly1_reg[DLY1-1];
    end

    // Restoring divider by twice the local radius, one quotient bit per stage.
    logic [D_W-1:0] div_rem_reg  [Q_W];
    logic [Q_W-1:0] div_low_reg  [Q_W];
    logic [Q_W-1:0] div_q_reg    [Q_W];
    logic           div_sat_reg  [Q_W];
    side_t          div_side_reg [Q_W];

    for (genvar i = 0; i < Q_W; i++) begin : g_div
        logic [D_W-1:0] rem_in;
        logic [Q_W-1:0] low_in;
        logic [Q_W-1:0] q_in;
        logic           sat_in;
        side_t          side_in;
        logic [D_W:0]   rem_sh;
        logic [D_W:0]   dext;
        logic           ge;

        if (i == 0) begin : g_first
            assign rem_in  = dv_rem_reg;
            assign low_in  = dv_low_reg;
            assign q_in    = '0;
            assign sat_in  = dv_sat_reg;
            assign side_in = dv_side_reg;
        end else begin : g_next
            assign rem_in  = div_rem_reg[i-1];
            assign low_in  = div_low_reg[i-1];
            assign q_in    = div_q_reg[i-1];
            assign sat_in  = div_sat_reg[i-1];
            assign side_in = div_side_reg[i-1];
        end

        assign rem_sh = {rem_in, low_in[Q_W-1-i]};
        assign dext   = {1'b0, side_in.d};
        assign ge     = (rem_sh >= dext);

        always_ff @(posedge clk)
        begin
            div_rem_reg[i]  <= ge ? D_W'(rem_sh - dext) : D_W'(rem_sh);
            div_low_reg[i]  <= low_in;
            div_q_reg[i]    <= {q_in[Q_W-2:0], ge};
            div_sat_reg[i]  <= sat_in;
            div_side_reg[i] <= side_in;
        end
    end

    // Scaled correction length, then times gain and phase.
    logic [Q_W-1:0]      l16;
    logic [GP_W+Q_W-1:0] g_prod;
    side_t               fin_side;

    assign l16      = div_sat_reg[Q_W-1] ? '1 : div_q_reg[Q_W-1];
    assign fin_side = div_side_reg[Q_W-1];

    iptc_mul #(.WA(GP_W), .WB(Q_W)) u_mul_g (
        .clk (clk), .a (fin_side.gp), .b (l16), .p (g_prod)
    );

    side_t dly2_reg [NS_G];
    for (genvar k = 0; k < NS_G; k++) begin : g_dly2
        if (k == 0) begin : g_first
            always_ff @(posedge clk)
                dly2_reg[k] <= fin_side;
        end else begin : g_next
            always_ff @(posedge clk)
                dly2_reg[k] <= dly2_reg[k-1];
        end
    end

    // Output stage: round, add to the height, saturate or pass through.
    side_t                    out_side;
    logic [Q_W:0]             rnd;
    logic signed [SUM_W-1:0]  dm_s, topo_s, sum;
    logic signed [TOPO_W-1:0] res;
    logic signed [TOPO_W-1:0] topo_corr_reg;
    logic                     err_out_reg;
    logic                     nodata_out_reg;

    assign out_side = dly2_reg[NS_G-1];
    assign rnd      = (Q_W+1)'(g_prod[GP_W+Q_W-1:GP_W]) + (Q_W+1)'(1 << (RND_SHIFT - 1));
    assign dm_s     = $signed(SUM_W'(rnd[Q_W:RND_SHIFT]));
    assign topo_s   = {{(SUM_W-TOPO_W){out_side.topo[TOPO_W-1]}}, out_side.topo};
    assign sum      = out_side.neg ? (topo_s - dm_s) : (topo_s + dm_s);

    always_comb
    begin
        if (out_side.err || out_side.nodata || !out_side.qpos)
            res = out_side.topo;
        else if (sum > TOPO_MAX)
            res = TOPO_MAX[TOPO_W-1:0];
        else if (sum < TOPO_MIN)
            res = TOPO_MIN[TOPO_W-1:0];
        else
            res = sum[TOPO_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        topo_corr_reg  <= res;
        err_out_reg    <= out_side.err;
        nodata_out_reg <= out_side.nodata;
    end

    assign done           = v_reg[PIPE_LAT-1];
    assign topo_corr      = topo_corr_reg;
    assign geometry_error = done & err_out_reg;
    assign was_nodata     = done & nodata_out_reg;

endmodule

>>> rtl/iptc_checker.sv
`include "insar_phase_to_topo_correction_unit_defines.svh"

// Port-level checks of the topography correction unit.
module iptc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic geometry_error,
    input logic was_nodata
);
    import iptc_pkg::*;

    // The pipeline takes a request in every cycle.
    `IPTC_ASSERT_NEVER(a_never_busy, busy)

    // Result flags are only shown with a result.
    `IPTC_ASSERT_IMPLIES(a_flags_with_done, geometry_error || was_nodata, done)

    // A result comes from a request taken a fixed latency earlier.
    `IPTC_ASSERT_IMPLIES(a_done_has_request, done, $past(start && !busy, PIPE_LAT))

endmodule

bind insar_phase_to_topo_correction_unit iptc_checker u_iptc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .geometry_error (geometry_error),
    .was_nodata     (was_nodata)
);

>>> sim/tb_insar_phase_to_topo_correction_unit.sv
`default_nettype none

module tb_insar_phase_to_topo_correction_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import iptc_pkg::*;

    // Register index that decodes to no register; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam logic [63:0] DEPTH_SAT = (64'd1 << 52) - 64'd1;
    localparam int SETTLE_CYCLES = PIPE_LAT + 20;

    typedef struct {
        logic [COL_W-1:0]          column;
        logic signed [TOPO_W-1:0]  topo;
        logic signed [PHASE_W-1:0] phase;
    } pixel_t;

    typedef struct {
        logic signed [TOPO_W-1:0] topo;
        logic                     geo_err;
        logic                     nodata;
    } height_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic [COL_W-1:0] column = '0;
    logic signed [TOPO_W-1:0] topo_in = '0;
    logic signed [PHASE_W-1:0] residual_phase = '0;
    logic done;
    logic signed [TOPO_W-1:0] topo_corr;
    logic geometry_error;
    logic was_nodata;

    // Shadow copy of the geometry, gain and nodata registers.
    longint near_mm = 0;
    longint spacing_mm = 0;
    longint radius_mm = 64'd6371000000;
    longint height_mm = 0;
    logic signed [GAIN_W-1:0] gain_q = '0;
    logic signed [PHASE_W-1:0] nodata_code = '0;

    pixel_t  pixel_backlog[$];
    height_t height_queue[$];
    logic    taken = 1'b0;
    int      burst_left = 0;
    int      gap_left = 0;
    int      errors = 0;

    insar_phase_to_topo_correction_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .column         (column),
        .topo_in        (topo_in),
        .residual_phase (residual_phase),
        .done           (done),
        .topo_corr      (topo_corr),
        .geometry_error (geometry_error),
        .was_nodata     (was_nodata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Bitwise integer square root of a 128-bit value.
    function automatic logic [127:0] int_root(logic [127:0] x);
        logic [63:0] r;
        logic [63:0] t;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            sq = {64'd0, t} * {64'd0, t};
            if (sq <= x)
                r = t;
        end
        return {64'd0, r};
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic terms_positive(longint a, longint b);
        return a != 0 && b != 0 && ((a < 0) == (b < 0));
    endfunction

    // Corrected height of one pixel under the current register values.
    function automatic height_t correct_height(pixel_t px);
        height_t h;
        longint rho, c, ret, a1, a2, a3, a4, res, gain_l, phase_l;
        logic [127:0] rp, rq, num, quo, prod;
        logic [63:0] depth, gp, dm;
        logic neg;
        gain_l = gain_q;
        phase_l = px.phase;
        rho = near_mm + longint'(px.column) * spacing_mm;
        c = radius_mm + height_mm;
        ret = radius_mm + longint'(px.topo);
        a1 = ret - c + rho;
        a2 = ret + c - rho;
        a3 = rho + c - ret;
        a4 = rho + c + ret;
        h.nodata = (px.phase == nodata_code);
        h.geo_err = (ret <= 0) || !terms_positive(a1, a2);
        res = px.topo;
        if (!h.geo_err && !h.nodata && terms_positive(a3, a4))
        begin
            rp = int_root(({64'd0, abs64(a1)} * {64'd0, abs64(a2)}) << 16);
            rq = int_root(({64'd0, abs64(a3)} * {64'd0, abs64(a4)}) << 16);
            num = rp * rq;
            quo = num / {64'd0, 64'(2 * ret)};
            depth = (quo > {64'd0, DEPTH_SAT}) ? DEPTH_SAT : quo[63:0];
            gp = abs64(gain_l) * abs64(phase_l);
            prod = {64'd0, gp} * {64'd0, depth};
            dm = (prod[127:64] + 64'd128) >> 8;
            neg = (gain_l < 0) != (phase_l < 0);
            res = res + (neg ? -longint'(dm) : longint'(dm));
            if (res > 16777215)
                res = 16777215;
            if (res < -16777216)
                res = -16777216;
        end
        h.topo = res[TOPO_W-1:0];
        return h;
    endfunction

    // Register write; the block is idle whenever this is called.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_NEAR_RANGE:      near_mm = longint'(value[31:0]);
            REG_RANGE_SPACING:   spacing_mm = longint'(value[19:0]);
            REG_EARTH_RADIUS:    radius_mm = longint'(value[33:0]);
            REG_PLATFORM_HEIGHT: height_mm = longint'(value[31:0]);
            REG_PHASE_GAIN:      gain_q = value[31:0];
            REG_NODATA_PHASE:    nodata_code = value[31:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_pixel(logic [COL_W-1:0] col, logic signed [TOPO_W-1:0] topo,
                               logic signed [PHASE_W-1:0] phase);
        pixel_t px;
        px.column = col;
        px.topo = topo;
        px.phase = phase;
        pixel_backlog.push_back(px);
    endtask

    // Random pixels: mostly plausible heights and phases, some full-range noise.
    task automatic queue_random(int n);
        logic [COL_W-1:0] col;
        logic signed [TOPO_W-1:0] topo;
        logic signed [PHASE_W-1:0] phase;
        for (int i = 0; i < n; i++)
        begin
            col = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                              : COL_W'($urandom);
            if ($urandom_range(0, 3) == 0)
                topo = TOPO_W'($urandom);
            else
                topo = TOPO_W'($signed($urandom_range(0, 20000000)) - 10000000);
            case ($urandom_range(0, 7))
                0: phase = nodata_code;
                1, 2: phase = $urandom;
                default: phase = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            endcase
            queue_pixel(col, topo, phase);
        end
    endtask

    // Waits until every request has been issued and every result has come back.
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pixel_backlog.size() != 0 || start || height_queue.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Request driver: bursts of requests separated by random gaps.
    always @(negedge clk)
    begin
        pixel_t px;
        if (rst_n && !(start && !taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pixel_backlog.size() > 0)
            begin
                px = pixel_backlog.pop_front();
                start <= 1'b1;
                column <= px.column;
                topo_in <= px.topo;
                residual_phase <= px.phase;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predicts each accepted request and checks each result.
    always @(posedge clk)
    begin
        pixel_t px;
        height_t exp_h;
        taken <= start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (height_queue.size() == 0)
                begin
                    $error("result with no request outstanding");
                    errors++;
                end
                else
                begin
                    exp_h = height_queue.pop_front();
                    if (topo_corr !== exp_h.topo)
                    begin
                        $error("topo_corr expected %0d actual %0d", exp_h.topo, topo_corr);
                        errors++;
                    end
                    if (geometry_error !== exp_h.geo_err)
                    begin
                        $error("geometry_error expected %0b actual %0b",
                               exp_h.geo_err, geometry_error);
                        errors++;
                    end
                    if (was_nodata !== exp_h.nodata)
                    begin
                        $error("was_nodata expected %0b actual %0b", exp_h.nodata, was_nodata);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                px.column = column;
                px.topo = topo_in;
                px.phase = residual_phase;
                height_queue.push_back(correct_height(px));
            end
        end
    end

    initial
    begin
        #3_000_000;
        $display("insar_phase_to_topo_correction_unit verification failed");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: zero slant range, so each height passes through uncorrected.
        queue_pixel(12'd5, 25'sd1000, 32'sd77);
        queue_pixel(12'd0, -25'sd16777216, 32'sd0);
        queue_random(60);
        wait_drained();

        // Orbit-like geometry with directed corner pixels.
        write_reg(REG_NEAR_RANGE, 64'd850000000);
        write_reg(REG_RANGE_SPACING, 64'd7000);
        write_reg(REG_EARTH_RADIUS, 64'd6371000000);
        write_reg(REG_PLATFORM_HEIGHT, 64'd700000000);
        write_reg(REG_PHASE_GAIN, 64'hF000_0000);
        write_reg(REG_NODATA_PHASE, 64'h8000_0000);
        write_reg(REG_UNMAPPED, 64'h3_FFFF_FFFF);
        queue_pixel(12'd0, 25'sd0, 32'sd1000);
        queue_pixel(12'hFFF, 25'sd0, 32'sd1000);
        queue_pixel(12'd100, 25'sd16777215, 32'sd2147483647);
        queue_pixel(12'd100, -25'sd16777216, 32'sd2147483647);
        queue_pixel(12'd100, 25'sd16777215, -32'sd2147483647);
        queue_pixel(12'd100, -25'sd16777216, -32'sd100);
        queue_pixel(12'd7, 25'sd1234, 32'h8000_0000);
        queue_pixel(12'hFFF, 25'sd0, 32'sd0);
        queue_pixel(12'd2048, -25'sd5000, -32'sd65536);
        queue_random(200);
        wait_drained();

        // Short ranges below the height difference raise the geometry error.
        write_reg(REG_NEAR_RANGE, 64'd0);
        write_reg(REG_RANGE_SPACING, 64'd1000000);
        write_reg(REG_PHASE_GAIN, 64'h1234_5678);
        write_reg(REG_NODATA_PHASE, 64'd0);
        queue_pixel(12'd0, 25'sd0, 32'sd5);
        queue_pixel(12'd1, 25'sd0, 32'sd0);
        queue_pixel(12'd700, 25'sd0, 32'sd9);
        queue_random(200);
        wait_drained();

        // Zero earth radius: non-positive local radius for low pixels.
        write_reg(REG_EARTH_RADIUS, 64'd0);
        write_reg(REG_PLATFORM_HEIGHT, 64'd3000000);
        write_reg(REG_RANGE_SPACING, 64'd1000);
        write_reg(REG_NEAR_RANGE, 64'd2000000);
        queue_pixel(12'd0, 25'sd0, 32'sd5);
        queue_pixel(12'd0, -25'sd1, 32'sd5);
        queue_pixel(12'd10, 25'sd1000000, 32'sd500);
        queue_random(150);
        wait_drained();

        // Near range, earth radius, platform height and nodata code at their top values.
        write_reg(REG_NEAR_RANGE, 64'hFFFF_FFFF);
        write_reg(REG_RANGE_SPACING, 64'd1000000);
        write_reg(REG_EARTH_RADIUS, 64'h3_FFFF_FFFF);
        write_reg(REG_PLATFORM_HEIGHT, 64'hFFFF_FFFF);
        write_reg(REG_PHASE_GAIN, 64'h8000_0000);
        write_reg(REG_NODATA_PHASE, 64'h7FFF_FFFF);
        queue_pixel(12'hFFF, 25'sd16777215, 32'sd2147483647);
        queue_pixel(12'd0, -25'sd16777216, -32'sd2147483648);
        queue_random(150);
        wait_drained();

        // Random plausible geometry.
        write_reg(REG_NEAR_RANGE, 64'($urandom_range(600000000, 1200000000)));
        write_reg(REG_RANGE_SPACING, 64'($urandom_range(1000, 30000)));
        write_reg(REG_EARTH_RADIUS, 64'd6300000000 + 64'($urandom_range(0, 100000000)));
        write_reg(REG_PLATFORM_HEIGHT, 64'($urandom_range(400000000, 900000000)));
        write_reg(REG_PHASE_GAIN, 64'($urandom));
        write_reg(REG_NODATA_PHASE, 64'($urandom));
        queue_random(200);
        wait_drained();

        if (errors == 0)
            $display("insar_phase_to_topo_correction_unit verification clean");
        else
            $display("insar_phase_to_topo_correction_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> insar_phase_to_topo_correction_unit.f
+incdir+rtl
rtl/iptc_pkg.sv
rtl/iptc_mul.sv
rtl/iptc_sqrt.sv
rtl/insar_phase_to_topo_correction_unit.sv
rtl/iptc_checker.sv
sim/tb_insar_phase_to_topo_correction_unit.sv
